// ----- rtl/hwd_pkg.sv -----
// ----------------------------------------------------------------------------
// hwd_pkg
// Shared types and constants for the tree-walk Huffman decoder.
// ----------------------------------------------------------------------------
package hwd_pkg;

  localparam int unsigned ALPHABET_DEF    = 256;
  localparam int unsigned SYMBOL_BITS_DEF = 8;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VALUE_W  = 8;
  localparam int unsigned SYMBOL_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WALK    = 2'd0,
    ACT_SYMBOL  = 2'd1,
    ACT_CODE    = 2'd2,
    ACT_RESTART = 2'd3
  } action_e;

  // controller -> datapath
  typedef struct packed {
    logic restart;
    logic latch;
    logic sym_write;
    logic desc_link;
    logic desc_mark;
    logic leaf_mark;
    logic climb_start;
    logic climb_par;
    logic climb_info;
    logic code_step;
    logic code_fail;
    logic code_enter;
    logic code_leaf;
    logic emit_err;
    logic emit_sym;
  } hwd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;
    logic descend;
    logic node_full;
    logic prev_bit;
    logic leaf_full;
    logic sym_full;
    logic child_ok;
    logic child_leaf;
  } hwd_status_t;

endpackage

// ----- rtl/huffman_tree_walk_decoder_top.sv -----
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top
// Rebuilds a Huffman tree from its walk bits and decodes code bits with it.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A leaf symbol,
// a restart, an ignored walk bit and a walk bit that overflows the node or
// leaf table are done in the state that accepts them. A descending walk bit
// links the new node, then marks it; a climbing walk bit, the one that climbs
// out of the root and ends the walk included, reads its parent, then the
// parent's info. Each node table has a single registered read port, so a
// code bit reads the current node, then the child's leaf flag, then the
// leaf's symbol, and stops early on a missing child or an inner node. A
// result shows on valid_o/symbol_o/error_o for one cycle right after the
// transaction's last cycle and must be taken then; the block never holds it.
// No clearing pass runs after reset or restart: the root's child flags sit in
// flops and every other node is initialized when the walk creates it.
module huffman_tree_walk_decoder_top #(
  parameter int unsigned ALPHABET    = hwd_pkg::ALPHABET_DEF,
  parameter int unsigned SYMBOL_BITS = hwd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [hwd_pkg::ACTION_W-1:0]      action_i,
  input  logic [hwd_pkg::VALUE_W-1:0]       value_i,
  output logic                              valid_o,
  output logic [hwd_pkg::SYMBOL_W-1:0]      symbol_o,
  output logic                              error_o
);

  hwd_pkg::hwd_cmd_t    cmd;
  hwd_pkg::hwd_status_t status;

  hwd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  hwd_datapath #(
    .ALPHABET    (ALPHABET),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .value_i  (value_i),
    .cmd_i    (cmd),
    .status_o (status),
    .valid_o  (valid_o),
    .symbol_o (symbol_o),
    .error_o  (error_o)
  );

endmodule

// ----- rtl/hwd_ram.sv -----
// ----------------------------------------------------------------------------
// hwd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/hwd_ctrl.sv -----
// ----------------------------------------------------------------------------
// hwd_ctrl
// Sequencer: decodes the accepted transaction and steps the datapath.
// ----------------------------------------------------------------------------
module hwd_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic [hwd_pkg::ACTION_W-1:0]      action_i,
  input  hwd_pkg::hwd_status_t              status_i,
  output hwd_pkg::hwd_cmd_t                 cmd_o,
  output logic                              busy
);

  typedef enum logic [6:0] {
    ST_IDLE       = 7'b0000001,
    ST_MARK       = 7'b0000010,
    ST_CLIMB_PAR  = 7'b0000100,
    ST_CLIMB_INFO = 7'b0001000,
    ST_CODE_NODE  = 7'b0010000,
    ST_CODE_CHILD = 7'b0100000,
    ST_CODE_SYM   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          case (hwd_pkg::action_e'(action_i))
            hwd_pkg::ACT_WALK: begin
              if (!status_i.walk_done) begin
                if (status_i.descend) begin
                  if (status_i.node_full) begin
                    cmd_o.emit_err = 1'b1;
                  end else begin
                    cmd_o.desc_link = 1'b1;
                    state_d         = ST_MARK;
                  end
                end else if (status_i.prev_bit && status_i.leaf_full) begin
                  cmd_o.emit_err = 1'b1;
                end else begin
                  cmd_o.leaf_mark   = status_i.prev_bit;
                  cmd_o.climb_start = 1'b1;
                  state_d           = ST_CLIMB_PAR;
                end
              end
            end
            hwd_pkg::ACT_SYMBOL: begin
              if (status_i.sym_full) begin
                cmd_o.emit_err = 1'b1;
              end else begin
                cmd_o.sym_write = 1'b1;
              end
            end
            hwd_pkg::ACT_CODE: begin
              state_d = ST_CODE_NODE;
            end
            hwd_pkg::ACT_RESTART: begin
              cmd_o.restart = 1'b1;
            end
            default: begin
              cmd_o.restart = 1'b1;
            end
          endcase
        end
      end
      ST_MARK: begin
        cmd_o.desc_mark = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_CLIMB_PAR: begin
        cmd_o.climb_par = 1'b1;
        state_d         = ST_CLIMB_INFO;
      end
      ST_CLIMB_INFO: begin
        cmd_o.climb_info = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_CODE_NODE: begin
        if (status_i.child_ok) begin
          cmd_o.code_step = 1'b1;
          state_d         = ST_CODE_CHILD;
        end else begin
          cmd_o.code_fail = 1'b1;
          cmd_o.emit_err  = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_CODE_CHILD: begin
        if (status_i.child_leaf) begin
          cmd_o.code_leaf = 1'b1;
          state_d         = ST_CODE_SYM;
        end else begin
          cmd_o.code_enter = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_CODE_SYM: begin
        cmd_o.emit_sym = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/hwd_datapath.sv -----
// ----------------------------------------------------------------------------
// hwd_datapath
// Node tables, leaf symbol table, walk/decode registers and result register.
// ----------------------------------------------------------------------------
module hwd_datapath #(
  parameter int unsigned ALPHABET    = hwd_pkg::ALPHABET_DEF,
  parameter int unsigned SYMBOL_BITS = hwd_pkg::SYMBOL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [hwd_pkg::VALUE_W-1:0]       value_i,
  input  hwd_pkg::hwd_cmd_t                 cmd_i,
  output hwd_pkg::hwd_status_t              status_o,
  output logic                              valid_o,
  output logic [hwd_pkg::SYMBOL_W-1:0]      symbol_o,
  output logic                              error_o
);

  localparam int unsigned NODE_MAX = 2 * ALPHABET;
  localparam int unsigned NODE_W   = $clog2(NODE_MAX);
  localparam int unsigned LEAF_W   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned INFO_W   = LEAF_W + 3;
  localparam int unsigned PRES_HI  = INFO_W - 1;
  localparam int unsigned PRES_LO  = INFO_W - 2;
  localparam int unsigned LEAF_BIT = LEAF_W;

  localparam logic [NODE_W:0] NodeMax  = (NODE_W + 1)'(NODE_MAX);
  localparam logic [LEAF_W:0] LeafMax  = (LEAF_W + 1)'(ALPHABET);

  // info word per node: {present[1:0], leaf, leaf number}
  logic [NODE_W-1:0] walk_node_q, dec_node_q, next_q;
  logic [NODE_W:0]   node_cnt_q;
  logic [LEAF_W:0]   leaf_cnt_q, sym_cnt_q;
  logic [1:0]        root_pres_q;
  logic [INFO_W-1:0] wk_info_q;
  logic              prev_bit_q, started_q, done_q, bit_q, side_left_q;
  logic              valid_q, error_q;
  logic [hwd_pkg::SYMBOL_W-1:0] symbol_q;

  logic [NODE_W-1:0]      new_node, par_rdata, left_rdata, right_rdata, child;
  logic [INFO_W-1:0]      info_rdata, info_wdata;
  logic [NODE_W-1:0]      info_waddr, info_raddr;
  logic                   info_we, side_left;
  logic [1:0]             cur_pres, side_mask;
  logic [SYMBOL_BITS-1:0] sym_rdata;

  assign new_node  = node_cnt_q[NODE_W-1:0];
  assign side_left = !started_q || prev_bit_q;
  assign side_mask = side_left_q ? 2'b01 : 2'b10;
  assign child     = bit_q ? right_rdata : left_rdata;
  // root's child bits live in flops so a restart needs no table sweep
  assign cur_pres  = (dec_node_q == '0) ? root_pres_q : info_rdata[PRES_HI:PRES_LO];

  always_comb begin
    info_we    = cmd_i.desc_link | cmd_i.desc_mark | cmd_i.leaf_mark;
    info_waddr = walk_node_q;
    info_wdata = {wk_info_q[PRES_HI:PRES_LO], 1'b1, leaf_cnt_q[LEAF_W-1:0]};
    if (cmd_i.desc_link) begin
      info_waddr = new_node;
      info_wdata = '0;
    end else if (cmd_i.desc_mark) begin
      info_wdata = {wk_info_q[PRES_HI:PRES_LO] | side_mask, wk_info_q[LEAF_BIT:0]};
    end
    if (cmd_i.climb_par) begin
      info_raddr = par_rdata;
    end else if (cmd_i.code_step) begin
      info_raddr = child;
    end else begin
      info_raddr = dec_node_q;
    end
  end

  hwd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_MAX)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.desc_link),
    .waddr_i (new_node),
    .wdata_i (walk_node_q),
    .raddr_i (walk_node_q),
    .rdata_o (par_rdata)
  );

  hwd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_MAX)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.desc_link & side_left),
    .waddr_i (walk_node_q),
    .wdata_i (new_node),
    .raddr_i (dec_node_q),
    .rdata_o (left_rdata)
  );

  hwd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_MAX)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.desc_link & !side_left),
    .waddr_i (walk_node_q),
    .wdata_i (new_node),
    .raddr_i (dec_node_q),
    .rdata_o (right_rdata)
  );

  hwd_ram #(.WIDTH(INFO_W), .DEPTH(NODE_MAX)) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (info_waddr),
    .wdata_i (info_wdata),
    .raddr_i (info_raddr),
    .rdata_o (info_rdata)
  );

  hwd_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(ALPHABET)) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sym_write),
    .waddr_i (sym_cnt_q[LEAF_W-1:0]),
    .wdata_i (SYMBOL_BITS'(value_i)),
    .raddr_i (info_rdata[LEAF_W-1:0]),
    .rdata_o (sym_rdata)
  );

  always_comb begin
    status_o.walk_done  = done_q;
    status_o.descend    = !started_q || value_i[0];
    status_o.node_full  = (node_cnt_q >= NodeMax);
    status_o.prev_bit   = prev_bit_q;
    status_o.leaf_full  = (leaf_cnt_q >= LeafMax);
    status_o.sym_full   = (sym_cnt_q >= leaf_cnt_q);
    status_o.child_ok   = bit_q ? cur_pres[1] : cur_pres[0];
    status_o.child_leaf = info_rdata[LEAF_BIT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_node_q <= '0;
      dec_node_q  <= '0;
      node_cnt_q  <= (NODE_W + 1)'(1);
      leaf_cnt_q  <= '0;
      sym_cnt_q   <= '0;
      root_pres_q <= '0;
      wk_info_q   <= '0;
      prev_bit_q  <= 1'b0;
      started_q   <= 1'b0;
      done_q      <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit_err | cmd_i.emit_sym;
      if (cmd_i.restart) begin
        walk_node_q <= '0;
        dec_node_q  <= '0;
        node_cnt_q  <= (NODE_W + 1)'(1);
        leaf_cnt_q  <= '0;
        sym_cnt_q   <= '0;
        root_pres_q <= '0;
        wk_info_q   <= '0;
        prev_bit_q  <= 1'b0;
        started_q   <= 1'b0;
        done_q      <= 1'b0;
      end
      if (cmd_i.sym_write) begin
        sym_cnt_q <= sym_cnt_q + (LEAF_W + 1)'(1);
      end
      if (cmd_i.desc_mark) begin
        if (walk_node_q == '0) begin
          root_pres_q <= root_pres_q | side_mask;
        end
        walk_node_q <= new_node;
        node_cnt_q  <= node_cnt_q + (NODE_W + 1)'(1);
        wk_info_q   <= '0;
        started_q   <= 1'b1;
        prev_bit_q  <= bit_q;
      end
      if (cmd_i.leaf_mark) begin
        leaf_cnt_q <= leaf_cnt_q + (LEAF_W + 1)'(1);
      end
      if (cmd_i.climb_start) begin
        prev_bit_q <= 1'b0;
        done_q     <= (walk_node_q == '0);
      end
      if (cmd_i.climb_par) begin
        walk_node_q <= par_rdata;
      end
      if (cmd_i.climb_info) begin
        wk_info_q <= (walk_node_q == '0) ? {root_pres_q, {(LEAF_W + 1){1'b0}}} : info_rdata;
      end
      if (cmd_i.code_fail || cmd_i.code_leaf) begin
        dec_node_q <= '0;
      end
      if (cmd_i.code_enter) begin
        dec_node_q <= next_q;
      end
    end
  end

  // transaction payload and result fields, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      bit_q <= value_i[0];
    end
    if (cmd_i.desc_link) begin
      side_left_q <= side_left;
    end
    if (cmd_i.code_step) begin
      next_q <= child;
    end
    error_q  <= cmd_i.emit_err;
    symbol_q <= cmd_i.emit_sym ? hwd_pkg::SYMBOL_W'(sym_rdata) : '0;
  end

  assign valid_o  = valid_q;
  assign symbol_o = symbol_q;
  assign error_o  = error_q;

endmodule

// ----- rtl/hwd_checker.sv -----
// ----------------------------------------------------------------------------
// hwd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hwd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic [hwd_pkg::ACTION_W-1:0]      action_i,
  input logic                              valid_o,
  input logic [hwd_pkg::SYMBOL_W-1:0]      symbol_o,
  input logic                              error_o
);

  logic accept;
  assign accept = start && !busy;

  // an error result carries no symbol
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && error_o |-> symbol_o == '0)
    else $error("error result with nonzero symbol");

  // restart does not make the block busy and produces nothing
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == hwd_pkg::ACT_RESTART |=> !busy && !valid_o)
    else $error("restart did not finish quietly");

  // a leaf symbol transaction does not make the block busy
  a_sym_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == hwd_pkg::ACT_SYMBOL |=> !busy)
    else $error("symbol transaction held the block busy");

  // a code bit always needs the node tables, so the block goes busy
  a_code_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == hwd_pkg::ACT_CODE |=> busy)
    else $error("code bit did not start a table lookup");

  // decoded symbols only come out of a code bit lookup
  a_sym_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !error_o |-> $past(busy))
    else $error("decoded symbol without a lookup");

endmodule

bind huffman_tree_walk_decoder_top hwd_checker u_hwd_checker (.*);

// ----- bench/huffman_tree_walk_decoder_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_top_tb
// Self-checking bench for the tree-walk Huffman decoder. Walk bits, leaf
// symbols, code bits and restarts are driven through the start/busy port.
// A local tree model predicts every strobed result, which is checked field by
// field. Directed cases cover the walk corner cases and table limits,
// and random streams of well-formed trees with noise run at several idle rates.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_top_tb;

  localparam int ALPHA      = hwd_pkg::ALPHABET_DEF;
  localparam int NODE_LIMIT = 2 * hwd_pkg::ALPHABET_DEF;
  localparam int STALL_MAX  = 2000;

  typedef struct packed {
    logic [hwd_pkg::SYMBOL_W-1:0] symbol;
    logic                         error;
  } decode_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [hwd_pkg::ACTION_W-1:0] action_i = '0;
  logic [hwd_pkg::VALUE_W-1:0]  value_i = '0;
  logic                         valid_o;
  logic [hwd_pkg::SYMBOL_W-1:0] symbol_o;
  logic                         error_o;

  // tree model
  logic [9:0]                   tree_left [NODE_LIMIT];
  logic [9:0]                   tree_right [NODE_LIMIT];
  logic [9:0]                   node_parent [NODE_LIMIT];
  logic [1:0]                   node_kids [NODE_LIMIT];
  logic                         node_is_leaf [NODE_LIMIT];
  logic [7:0]                   node_leaf_idx [NODE_LIMIT];
  logic [hwd_pkg::SYMBOL_W-1:0] leaf_sym [ALPHA];
  int                           walk_at;
  int                           decode_at;
  int                           node_cnt;
  int                           leaf_cnt;
  int                           sym_cnt;
  logic                         last_walk_bit;
  logic                         walk_begun;
  logic                         walk_over;

  decode_result_t      expected_q[$];
  decode_result_t      want;
  int                  fail_cnt = 0;
  int                  sent_items = 0;
  int                  send_idle_pct = 0;
  int                  stall_cycles = 0;

  huffman_tree_walk_decoder_top u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .action_i (action_i),
    .value_i  (value_i),
    .valid_o  (valid_o),
    .symbol_o (symbol_o),
    .error_o  (error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void clear_tree();
    for (int i = 0; i < NODE_LIMIT; i++) begin
      node_kids[i]    = 2'b00;
      node_is_leaf[i] = 1'b0;
    end
    walk_at       = 0;
    decode_at     = 0;
    node_cnt      = 1;
    leaf_cnt      = 0;
    sym_cnt       = 0;
    last_walk_bit = 1'b0;
    walk_begun    = 1'b0;
    walk_over     = 1'b0;
  endfunction

  // Returns 1 when the transaction produces a result.
  function automatic bit predict_decode(input hwd_pkg::action_e act,
                                        input logic [7:0] val,
                                        output decode_result_t res);
    int n;
    int nxt;
    res = '0;
    case (act)
      hwd_pkg::ACT_WALK: begin
        if (walk_over) return 0;
        if (!walk_begun || val[0]) begin
          if (node_cnt >= NODE_LIMIT) begin
            res.error = 1'b1;
            return 1;
          end
          n = node_cnt;
          node_cnt++;
          node_parent[n]  = 10'(walk_at);
          node_kids[n]    = 2'b00;
          node_is_leaf[n] = 1'b0;
          // first bit always goes left; otherwise a 1 after a 0 goes right
          if (!walk_begun || last_walk_bit) begin
            tree_left[walk_at]    = 10'(n);
            node_kids[walk_at][0] = 1'b1;
          end else begin
            tree_right[walk_at]   = 10'(n);
            node_kids[walk_at][1] = 1'b1;
          end
          walk_at       = n;
          walk_begun    = 1'b1;
          last_walk_bit = val[0];
          return 0;
        end
        if (last_walk_bit) begin
          if (leaf_cnt >= ALPHA) begin
            res.error = 1'b1;
            return 1;
          end
          node_is_leaf[walk_at]  = 1'b1;
          node_leaf_idx[walk_at] = 8'(leaf_cnt);
          leaf_cnt++;
        end
        if (walk_at == 0) walk_over = 1'b1;
        else walk_at = int'(node_parent[walk_at]);
        last_walk_bit = 1'b0;
        return 0;
      end
      hwd_pkg::ACT_SYMBOL: begin
        if (sym_cnt >= leaf_cnt || sym_cnt >= ALPHA) begin
          res.error = 1'b1;
          return 1;
        end
        leaf_sym[sym_cnt] = val;
        sym_cnt++;
        return 0;
      end
      hwd_pkg::ACT_CODE: begin
        if (!node_kids[decode_at][val[0]]) begin
          decode_at = 0;
          res.error = 1'b1;
          return 1;
        end
        nxt = val[0] ? int'(tree_right[decode_at]) : int'(tree_left[decode_at]);
        if (node_is_leaf[nxt]) begin
          decode_at  = 0;
          res.symbol = leaf_sym[node_leaf_idx[nxt]];
          return 1;
        end
        decode_at = nxt;
        return 0;
      end
      default: begin
        clear_tree();
        return 0;
      end
    endcase
  endfunction

  // A code bit must never land on a leaf whose symbol has not arrived yet.
  function automatic bit code_reads_unset(input logic b);
    int nxt;
    if (!node_kids[decode_at][b]) return 0;
    nxt = b ? int'(tree_right[decode_at]) : int'(tree_left[decode_at]);
    return node_is_leaf[nxt] && (int'(node_leaf_idx[nxt]) >= sym_cnt);
  endfunction

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_item(input hwd_pkg::action_e act, input logic [7:0] val);
    decode_result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    start    <= 1'b1;
    action_i <= act;
    value_i  <= val;
    do @(posedge clk_i); while (busy);
    // ignored walk bits do not count toward the stimulus amount
    if (!(act == hwd_pkg::ACT_WALK && walk_over)) sent_items++;
    if (predict_decode(act, val, res)) expected_q.push_back(res);
  endtask

  task automatic send_walk_bit(input logic b);
    send_item(hwd_pkg::ACT_WALK, {7'($urandom_range(127)), b});
  endtask

  task automatic send_code_guarded(input logic b);
    if (code_reads_unset(b)) b = ~b;
    if (code_reads_unset(b)) return;
    send_item(hwd_pkg::ACT_CODE, {7'($urandom_range(127)), b});
  endtask

  task automatic send_code_random();
    logic [1:0] kids;
    logic       b;
    kids = node_kids[decode_at];
    if ($urandom_range(99) < 90 && kids != 2'b00)
      b = (kids == 2'b11) ? 1'($urandom_range(1)) : kids[1];
    else
      b = 1'($urandom_range(1));
    send_code_guarded(b);
  endtask

  task automatic test_directed_walks();
    // empty tree: missing child at the root
    send_item(hwd_pkg::ACT_CODE, 8'h00);
    // first walk bit is a 0 yet still descends left, leaving an empty inner node
    send_item(hwd_pkg::ACT_WALK, 8'hFE);
    send_item(hwd_pkg::ACT_WALK, 8'h00);
    send_item(hwd_pkg::ACT_WALK, 8'h01);
    send_item(hwd_pkg::ACT_WALK, 8'h80);
    send_item(hwd_pkg::ACT_WALK, 8'h00);
    send_item(hwd_pkg::ACT_SYMBOL, 8'hFF);
    send_item(hwd_pkg::ACT_CODE, 8'h81);
    send_item(hwd_pkg::ACT_CODE, 8'h00);
    send_item(hwd_pkg::ACT_CODE, 8'h02);
    send_item(hwd_pkg::ACT_WALK, 8'h01);   // after walk end: ignored
    send_item(hwd_pkg::ACT_SYMBOL, 8'h00); // excess symbol
    send_item(hwd_pkg::ACT_RESTART, 8'h00);
    // comb walk that writes the root's right child twice
    send_item(hwd_pkg::ACT_WALK, 8'h01);
    send_item(hwd_pkg::ACT_WALK, 8'h00);
    send_item(hwd_pkg::ACT_WALK, 8'h03);
    send_item(hwd_pkg::ACT_WALK, 8'hF0);
    send_item(hwd_pkg::ACT_WALK, 8'h55);
    send_item(hwd_pkg::ACT_WALK, 8'hAA);
    send_item(hwd_pkg::ACT_WALK, 8'h0E);
    send_item(hwd_pkg::ACT_SYMBOL, 8'h01);
    send_item(hwd_pkg::ACT_SYMBOL, 8'h80);
    send_item(hwd_pkg::ACT_SYMBOL, 8'h7F);
    send_item(hwd_pkg::ACT_SYMBOL, 8'hAA);
    send_item(hwd_pkg::ACT_CODE, 8'hFE);
    send_item(hwd_pkg::ACT_CODE, 8'hFF);
    send_item(hwd_pkg::ACT_RESTART, 8'hFF);
  endtask

  task automatic test_table_limits();
    // fill the leaf table with a comb, then the node table with a left chain
    send_item(hwd_pkg::ACT_RESTART, 8'($urandom_range(255)));
    for (int i = 0; i < ALPHA; i++) begin
      send_walk_bit(1'b1);
      send_walk_bit(1'b0);
    end
    send_walk_bit(1'b1);
    send_walk_bit(1'b0);          // leaf overflow
    while (node_cnt < NODE_LIMIT) send_walk_bit(1'b1);
    send_walk_bit(1'b1);          // node overflow
    send_walk_bit(1'b0);          // leaf overflow again
    for (int i = 0; i < ALPHA; i++) send_item(hwd_pkg::ACT_SYMBOL, pick_symbol());
    send_item(hwd_pkg::ACT_SYMBOL, pick_symbol());
    send_code_guarded(1'b0);
    send_code_guarded(1'b1);
    send_code_guarded(1'b1);
    send_code_guarded(1'b1);
    send_code_guarded(1'b0);
    send_code_guarded(1'b0);
    send_item(hwd_pkg::ACT_RESTART, 8'($urandom_range(255)));
  endtask

  task automatic run_stream_round();
    int                mode;
    int                leaves;
    int                n;
    int                a;
    int                cut;
    int                nsym;
    int                ncode;
    int                split_q[$];
    logic              walk_q[$];
    hwd_pkg::action_e  act;
    mode   = $urandom_range(99);
    leaves = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 2);
    // walk bits of a random full tree, built without recursion
    split_q.push_back(-1);
    a = $urandom_range(leaves - 1, 1);
    split_q.push_back(leaves - a);
    split_q.push_back(a);
    while (split_q.size() != 0) begin
      n = split_q.pop_back();
      if (n < 0) begin
        walk_q.push_back(1'b0);
      end else if (n == 1) begin
        walk_q.push_back(1'b1);
        walk_q.push_back(1'b0);
      end else begin
        walk_q.push_back(1'b1);
        a = $urandom_range(n - 1, 1);
        split_q.push_back(-1);
        split_q.push_back(n - a);
        split_q.push_back(a);
      end
    end
    // a few rounds keep the old tree; some cut the walk short
    if (mode >= 8) send_item(hwd_pkg::ACT_RESTART, 8'($urandom_range(255)));
    cut = (mode >= 8 && mode < 18) ? $urandom_range(walk_q.size() - 1) : walk_q.size();
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(99) < 6) send_code_random();
      send_walk_bit(walk_q[i]);
    end
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(3, 1)) send_walk_bit(1'($urandom_range(1)));
    end
    nsym = leaf_cnt - sym_cnt;
    if (mode >= 90) nsym += $urandom_range(2, 1);
    else if (mode >= 80 && nsym > 0) nsym = $urandom_range(nsym - 1);
    repeat (nsym) send_item(hwd_pkg::ACT_SYMBOL, pick_symbol());
    ncode = $urandom_range(4 * leaves + 4, leaves);
    repeat (ncode) send_code_random();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(4, 1)) begin
        act = hwd_pkg::action_e'($urandom_range(3));
        if (act == hwd_pkg::ACT_CODE) send_code_guarded(1'($urandom_range(1)));
        else send_item(act, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic test_random_streams(input int count);
    int stop_at;
    stop_at = sent_items + count;
    while (sent_items < stop_at) run_stream_round();
  endtask

  // result check
  always @(posedge clk_i) begin
    if (valid_o === 1'b1) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result without transaction: symbol %02h error %0b",
                 $time, symbol_o, error_o);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (symbol_o !== want.symbol) begin
          $display("%0t: symbol mismatch: expected %02h, got %02h",
                   $time, want.symbol, symbol_o);
          fail_cnt++;
        end
        if (error_o !== want.error) begin
          $display("%0t: error mismatch: expected %0b, got %0b",
                   $time, want.error, error_o);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction and no result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
        $display("huffman_tree_walk_decoder_top_tb failed");
        $finish;
      end
    end
  end

  initial begin
    clear_tree();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 35;
    test_directed_walks();
    test_random_streams(10);
    send_idle_pct = 54;
    test_table_limits();
    test_random_streams(10);
    send_idle_pct = 0;
    test_random_streams(10);

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("huffman_tree_walk_decoder_top_tb passed");
    end else begin
      $display("huffman_tree_walk_decoder_top_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hwd_pkg.sv
rtl/hwd_ram.sv
rtl/hwd_ctrl.sv
rtl/hwd_datapath.sv
rtl/huffman_tree_walk_decoder_top.sv
rtl/hwd_checker.sv
bench/huffman_tree_walk_decoder_top_tb.sv
